[rtl/core/ile_pkg.sv]
// Shared types and constants of the indexed list engine.
// Used by ile_cell, ile_gather and indexed_list_engine; depends on nothing.
package ile_pkg;

    // Request codes carried on req_type.
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    // Widest cell index that the supported depths need.
    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;

    // Update that every cell applies in the same cycle.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_INSERT,
        CMD_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    tgt;
        logic                rd_en;
        logic [IDX_W-1:0]    rd_idx;
        logic [DATA_W-1:0]   val;
    } cell_cmd_t;

endpackage

[rtl/core/ile_cell.sv]
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on ile_pkg for the command type.
module ile_cell
(
    input  logic                          clk,
    input  ile_pkg::cell_cmd_t            cmd,
    input  logic [ile_pkg::IDX_W-1:0]     cell_idx,
    input  logic [ile_pkg::DATA_W-1:0]    left_data,
    input  logic [ile_pkg::DATA_W-1:0]    right_data,
    output logic [ile_pkg::DATA_W-1:0]    data,
    output logic [ile_pkg::DATA_W-1:0]    rd_data
);

    logic [ile_pkg::DATA_W-1:0] data_reg;
    logic [ile_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            ile_pkg::CMD_NONE:
            begin
                data_next = data_reg;
            end
            ile_pkg::CMD_WRITE:
            begin
                if (cell_idx == cmd.tgt)
                begin
                    data_next = cmd.val;
                end
            end
            ile_pkg::CMD_INSERT:
            begin
                if (cell_idx > cmd.tgt)
                begin
                    data_next = left_data;
                end
                else if (cell_idx == cmd.tgt)
                begin
                    data_next = cmd.val;
                end
            end
            ile_pkg::CMD_REMOVE:
            begin
                if (cell_idx >= cmd.tgt)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // The addressed cell puts its pre-update entry on the read path; all others give zero.
    assign rd_data = (cmd.rd_en && (cell_idx == cmd.rd_idx)) ? data_reg : '0;

endmodule

[rtl/core/ile_gather.sv]
// Two-level OR reduction of the cells' read outputs, registered per group of eight.
// Depends on ile_pkg for the data width.
module ile_gather #(
    parameter int DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          capture,
    input  logic [ile_pkg::DATA_W-1:0]    cell_rd [DEPTH],
    output logic [ile_pkg::DATA_W-1:0]    rd_value
);

    localparam int GRP    = 8;
    localparam int NGROUP = (DEPTH + GRP - 1) / GRP;

    logic [ile_pkg::DATA_W-1:0] grp_reg  [NGROUP];
    logic [ile_pkg::DATA_W-1:0] grp_next [NGROUP];

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < DEPTH)
                begin
                    grp_next[g] = grp_next[g] | cell_rd[g * GRP + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb
    begin
        rd_value = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            rd_value = rd_value | grp_reg[g];
        end
    end

endmodule

[rtl/core/indexed_list_engine.sv]
// Indexed list engine: top level, a row of ile_cell entries read through ile_gather.
// A request accepted into stage one reaches the output register through the two-step read
// path (cell compare into group registers, then the group OR into the result register);
// a new request is taken only once the last has left stage one and stage two is empty or drains.
// Reset clears the fill count and all handshake state; cell contents stay undefined
// until written. Depends on ile_pkg, ile_cell and ile_gather.
module indexed_list_engine #(
    parameter int DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [6:0]                    position,
    input  logic signed [31:0]            in_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic signed [31:0]            out_value,
    output logic [6:0]                    count
);

    // Fill count must hold DEPTH itself; compares run at the wider of it and the position.
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // Pipeline: stage one holds the accepted request and drives the cells; stage two
    // waits for the gathered read value; the output register holds a finished result
    // until the consumer takes it, so a new request can enter while it waits.
    logic                       s1_valid_reg;
    logic [2:0]                 s1_op_reg;
    logic [6:0]                 s1_pos_reg;
    logic [31:0]                s1_val_reg;

    logic                       s2_valid_reg;
    logic                       s2_ok_reg;
    logic [6:0]                 s2_count_reg;

    logic                       out_valid_reg;
    logic                       ok_reg;
    logic [31:0]                out_value_reg;
    logic [6:0]                 count_reg;

    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              fill_next;

    logic                       in_accept;
    logic                       s2_advance;
    logic                       req_ok;
    ile_pkg::cell_cmd_t         cmd;

    logic [CMPW-1:0]            fill_cmp;
    logic [CMPW-1:0]            pos_cmp;
    logic [CMPW-1:0]            depth_cmp;

    logic [ile_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [ile_pkg::DATA_W-1:0] cell_rd   [DEPTH];
    logic [ile_pkg::DATA_W-1:0] rd_value;

    // The result in stage two moves out when the output register is empty or being taken.
    assign s2_advance = s2_valid_reg && (!out_valid_reg || !out_stall);
    // A new request enters only when stage one is free and stage two is empty or drains
    // at this edge, so stage one always moves on in the following cycle.
    assign in_stall   = s1_valid_reg || (s2_valid_reg && !s2_advance);
    assign in_accept  = in_valid && !in_stall;

    assign fill_cmp  = CMPW'(fill_reg);
    assign pos_cmp   = CMPW'(s1_pos_reg);
    assign depth_cmp = CMPW'(DEPTH);

    // Decode the request in stage one against the current fill count. A failed request
    // drives no cell update and no read, so its read value comes back as zero.
    always_comb
    begin
        req_ok     = 1'b0;
        fill_next  = fill_reg;
        cmd.op     = ile_pkg::CMD_NONE;
        cmd.tgt    = ile_pkg::IDX_W'(s1_pos_reg);
        cmd.rd_en  = 1'b0;
        cmd.rd_idx = ile_pkg::IDX_W'(s1_pos_reg);
        cmd.val    = s1_val_reg;
        if (s1_valid_reg)
        begin
            unique case (s1_op_reg)
                ile_pkg::OP_PUSH:
                begin
                    if (fill_cmp < depth_cmp)
                    begin
                        req_ok    = 1'b1;
                        cmd.op    = ile_pkg::CMD_WRITE;
                        cmd.tgt   = ile_pkg::IDX_W'(fill_reg);
                        fill_next = fill_reg + CW'(1);
                    end
                end
                ile_pkg::OP_POP:
                begin
                    if (fill_cmp != '0)
                    begin
                        req_ok     = 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = ile_pkg::IDX_W'(fill_reg - CW'(1));
                        fill_next  = fill_reg - CW'(1);
                    end
                end
                ile_pkg::OP_GET:
                begin
                    if (pos_cmp < fill_cmp)
                    begin
                        req_ok    = 1'b1;
                        cmd.rd_en = 1'b1;
                    end
                end
                ile_pkg::OP_INSERT:
                begin
                    if ((fill_cmp < depth_cmp) && (pos_cmp <= fill_cmp))
                    begin
                        req_ok    = 1'b1;
                        cmd.op    = ile_pkg::CMD_INSERT;
                        fill_next = fill_reg + CW'(1);
                    end
                end
                ile_pkg::OP_REMOVE:
                begin
                    if (pos_cmp < fill_cmp)
                    begin
                        req_ok    = 1'b1;
                        cmd.op    = ile_pkg::CMD_REMOVE;
                        cmd.rd_en = 1'b1;
                        fill_next = fill_reg - CW'(1);
                    end
                end
                default:
                begin
                    req_ok = 1'b0;
                end
            endcase
        end
    end

    // The row of cells. The end cells see zero past the edge of the list.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [ile_pkg::DATA_W-1:0] left_data;
        logic [ile_pkg::DATA_W-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_left
            assign left_data = cell_data[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_right
            assign right_data = cell_data[k+1];
        end

        ile_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cell_idx   (ile_pkg::IDX_W'(k)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k]),
            .rd_data    (cell_rd[k])
        );
    end

    ile_gather #(
        .DEPTH (DEPTH)
    ) u_gather (
        .clk      (clk),
        .capture  (s1_valid_reg),
        .cell_rd  (cell_rd),
        .rd_value (rd_value)
    );

    // Control state: pipeline valids, fill count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (s1_valid_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_advance)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            fill_reg <= fill_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= req_type;
            s1_pos_reg <= position;
            s1_val_reg <= in_value;
        end
        if (s1_valid_reg)
        begin
            s2_ok_reg    <= req_ok;
            s2_count_reg <= 7'(fill_next);
        end
        if (s2_advance)
        begin
            ok_reg        <= s2_ok_reg;
            out_value_reg <= rd_value;
            count_reg     <= s2_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign out_value = out_value_reg;
    assign count     = count_reg;

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(fill_reg) <= CMPW'(DEPTH))
        else $error("fill count exceeds capacity");

    // A request in stage one always finds stage two free.
    a_s1_s2_free: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !s2_valid_reg)
        else $error("stage two occupied while stage one holds a request");

    // Stage one always moves into stage two in the next cycle.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("request lost between stage one and stage two");

    // Only a request in stage one may change the fill count.
    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> $stable(fill_reg))
        else $error("fill count changed without a request");

    // A failed request never returns a nonzero value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_advance && !s2_ok_reg) |=> (out_value_reg == '0))
        else $error("failed request returned a value");
`endif

endmodule
